// ===== rtl/hsvab_pkg.sv =====
// Package for the HSV adjust and blend unit: register codes, reset values
// and fixed field widths. No dependencies.
`default_nettype none

package hsvab_pkg;

  // Default width of one color channel.
  localparam int CHANNEL_BITS = 16;

  // Hue is a fraction of one turn held in this many bits.
  localparam int HUE_BITS = 16;

  localparam int GAIN_BITS  = 16;
  localparam int BLEND_BITS = 17;

  localparam logic [HUE_BITS-1:0]   HUE_SHIFT_RST = '0;
  localparam logic [GAIN_BITS-1:0]  GAIN_UNITY    = 16'd16384;
  localparam logic [BLEND_BITS-1:0] BLEND_ONE     = 17'd65536;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_HUE_SHIFT,
    CFG_SAT_GAIN,
    CFG_VAL_GAIN,
    CFG_BLEND
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/hsv_adjust_blend_unit.sv =====
// HSV adjust and blend unit, top level. Depends on hsvab_pkg and hsvab_div.
// done_o follows each accept through a valid chain as deep as the data path;
// QW = max(CHANNEL_BITS + 1, 17), and the two pipelined dividers set much of that depth.
// Throughput: one pixel word per cycle; busy_o never rises. The receiver cannot stall.
// Reset clears the valid bits and loads the register reset values.
`default_nettype none

module hsv_adjust_blend_unit #(
  parameter int CHANNEL_BITS = hsvab_pkg::CHANNEL_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [CHANNEL_BITS-1:0] red_in_i,
  input  wire logic [CHANNEL_BITS-1:0] green_in_i,
  input  wire logic [CHANNEL_BITS-1:0] blue_in_i,
  input  wire logic [CHANNEL_BITS-1:0] alpha_in_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [1:0]              cfg_index_i,
  input  wire logic [16:0]             cfg_data_i,
  output logic                         done_o,
  output logic      [CHANNEL_BITS-1:0] red_out_o,
  output logic      [CHANNEL_BITS-1:0] green_out_o,
  output logic      [CHANNEL_BITS-1:0] blue_out_o,
  output logic      [CHANNEL_BITS-1:0] alpha_out_o
);

  localparam int N   = CHANNEL_BITS;
  localparam int HB  = hsvab_pkg::HUE_BITS;
  localparam int GB  = hsvab_pkg::GAIN_BITS;
  localparam int BB  = hsvab_pkg::BLEND_BITS;
  localparam int QW  = (N + 1 > HB + 1) ? N + 1 : HB + 1;
  localparam int SDW = 2 * N + 1;
  localparam int HDW = N + HB + 3;
  localparam int HVW = N + 3;

  typedef logic [N-1:0] ch_t;
  typedef logic [N:0]   fr_t;

  typedef struct packed {
    logic byp;
    ch_t  r;
    ch_t  g;
    ch_t  b;
    ch_t  a;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    ch_t  v;
    logic dz;
    logic mz;
  } side_t;

  localparam fr_t FR_ONE = {1'b1, {N{1'b0}}};
  localparam ch_t CH_MAX = '1;

  // ---------------- configuration registers ----------------
  logic [HB-1:0] hue_shift_q;
  logic [GB-1:0] sat_gain_q;
  logic [GB-1:0] val_gain_q;
  logic [BB-1:0] blend_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_shift_q <= hsvab_pkg::HUE_SHIFT_RST;
      sat_gain_q  <= hsvab_pkg::GAIN_UNITY;
      val_gain_q  <= hsvab_pkg::GAIN_UNITY;
      blend_q     <= hsvab_pkg::BLEND_ONE;
    end else if (cfg_valid_i) begin
      unique case (hsvab_pkg::cfg_idx_e'(cfg_index_i))
        hsvab_pkg::CFG_HUE_SHIFT: hue_shift_q <= cfg_data_i[HB-1:0];
        hsvab_pkg::CFG_SAT_GAIN:  sat_gain_q  <= cfg_data_i[GB-1:0];
        hsvab_pkg::CFG_VAL_GAIN:  val_gain_q  <= cfg_data_i[GB-1:0];
        hsvab_pkg::CFG_BLEND:     blend_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [BB-1:0] fac;
  logic [BB-1:0] inv_fac;
  logic          byp_now;

  assign fac     = (blend_q > hsvab_pkg::BLEND_ONE) ? hsvab_pkg::BLEND_ONE : blend_q;
  assign inv_fac = hsvab_pkg::BLEND_ONE - fac;
  assign byp_now = (fac == '0) ||
                   ((hue_shift_q == '0) && (sat_gain_q == hsvab_pkg::GAIN_UNITY) &&
                    (val_gain_q == hsvab_pkg::GAIN_UNITY));

  // ---------------- valid chain ----------------
  localparam int NV = 13 + QW;
  logic [NV-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NV-2:0], start_i};
    end
  end

  // ---------------- stage 1: input words ----------------
  pix_t p1_q;

  always_ff @(posedge clk_i) begin
    p1_q <= '{byp: byp_now, r: red_in_i, g: green_in_i, b: blue_in_i, a: alpha_in_i};
  end

  // ---------------- stage 2: max, min, hue difference ----------------
  pix_t              p2_q;
  ch_t               mx2_q, mn2_q;
  logic signed [N:0] diff2_q;
  logic [2:0]        m2_q;

  logic signed [N:0] rg_d, gb_d, br_d;
  logic              r_max, g_max;

  assign gb_d  = $signed({1'b0, p1_q.g}) - $signed({1'b0, p1_q.b});
  assign br_d  = $signed({1'b0, p1_q.b}) - $signed({1'b0, p1_q.r});
  assign rg_d  = $signed({1'b0, p1_q.r}) - $signed({1'b0, p1_q.g});
  assign r_max = (p1_q.r >= p1_q.g) && (p1_q.r >= p1_q.b);
  assign g_max = !r_max && (p1_q.g >= p1_q.b);

  always_ff @(posedge clk_i) begin
    p2_q <= p1_q;
    if (r_max) begin
      mx2_q <= p1_q.r;
    end else if (g_max) begin
      mx2_q <= p1_q.g;
    end else begin
      mx2_q <= p1_q.b;
    end
    if (p1_q.r <= p1_q.g && p1_q.r <= p1_q.b) begin
      mn2_q <= p1_q.r;
    end else if (p1_q.g <= p1_q.b) begin
      mn2_q <= p1_q.g;
    end else begin
      mn2_q <= p1_q.b;
    end
    // The numerator is diff + m * d; m is the sector offset, with a full
    // six-sector wrap when red is largest and the difference is negative.
    if (r_max) begin
      diff2_q <= gb_d;
      m2_q    <= gb_d[N] ? 3'd6 : 3'd0;
    end else if (g_max) begin
      diff2_q <= br_d;
      m2_q    <= 3'd2;
    end else begin
      diff2_q <= rg_d;
      m2_q    <= 3'd4;
    end
  end

  // ---------------- stage 3: delta and saturation dividend ----------------
  pix_t              p3_q;
  ch_t               mx3_q, d3_q;
  logic signed [N:0] diff3_q;
  logic [2:0]        m3_q;
  logic [SDW-1:0]    sdvd3_q;
  ch_t               dlt;

  assign dlt = mx2_q - mn2_q;

  always_ff @(posedge clk_i) begin
    p3_q    <= p2_q;
    mx3_q   <= mx2_q;
    d3_q    <= dlt;
    diff3_q <= diff2_q;
    m3_q    <= m2_q;
    // max / 2 stays below 2^N, so the rounding term just fills the low half.
    sdvd3_q <= {1'b0, dlt, mx2_q >> 1};
  end

  // ---------------- stage 4: hue numerator ----------------
  pix_t           p4_q;
  ch_t            mx4_q;
  logic [N+2:0]   num4_q;
  logic [N+1:0]   dd3_4_q;
  logic [N+2:0]   dd6_4_q;
  logic [SDW-1:0] sdvd4_q;
  logic           dz4_q, mz4_q;

  logic [N+3:0] md;
  logic [N+3:0] num_full;

  assign md       = (N+4)'(m3_q) * (N+4)'(d3_q);
  assign num_full = (N+4)'(diff3_q) + md;

  always_ff @(posedge clk_i) begin
    p4_q    <= p3_q;
    mx4_q   <= mx3_q;
    num4_q  <= num_full[N+2:0];
    dd3_4_q <= (N+2)'(d3_q) + {d3_q, 1'b0};
    dd6_4_q <= {(N+2)'(d3_q) + {d3_q, 1'b0}, 1'b0};
    sdvd4_q <= sdvd3_q;
    dz4_q   <= (d3_q == '0);
    mz4_q   <= (mx3_q == '0);
  end

  // ---------------- stage 5: divider operands ----------------
  side_t          side5_q;
  logic [HDW-1:0] hdvd5_q;
  logic [HVW-1:0] hdvs5_q;
  logic [SDW-1:0] sdvd5_q;

  always_ff @(posedge clk_i) begin
    side5_q <= '{pix: p4_q, v: mx4_q, dz: dz4_q, mz: mz4_q};
    hdvd5_q <= {num4_q, {HB{1'b0}}} + HDW'(dd3_4_q);
    hdvs5_q <= dd6_4_q;
    sdvd5_q <= sdvd4_q;
  end

  // ---------------- dividers ----------------
  logic [QW-1:0] hq, sq;

  hsvab_div #(.DW(HDW), .VW(HVW), .QW(QW)) u_hue_div (
    .clk_i      (clk_i),
    .dividend_i (hdvd5_q),
    .divisor_i  (hdvs5_q),
    .quotient_o (hq)
  );

  hsvab_div #(.DW(SDW), .VW(N), .QW(QW)) u_sat_div (
    .clk_i      (clk_i),
    .dividend_i (sdvd5_q),
    .divisor_i  (side5_q.v),
    .quotient_o (sq)
  );

  side_t side_q [QW];

  always_ff @(posedge clk_i) begin
    side_q[0] <= side5_q;
    for (int i = 1; i < QW; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  side_t sd;
  assign sd = side_q[QW-1];

  // ---------------- stage 6: hue shift and gain products ----------------
  pix_t          p6_q;
  logic [HB-1:0] h6_q;
  logic [N+16:0] sp6_q;
  logic [N+15:0] vp6_q;

  logic [HB-1:0] h_raw;
  fr_t           s_raw;

  assign h_raw = sd.dz ? '0 : hq[HB-1:0];
  assign s_raw = sd.mz ? '0 : sq[N:0];

  always_ff @(posedge clk_i) begin
    p6_q  <= sd.pix;
    h6_q  <= h_raw + hue_shift_q;
    sp6_q <= (N+17)'(s_raw) * (N+17)'(sat_gain_q);
    vp6_q <= (N+16)'(sd.v) * (N+16)'(val_gain_q);
  end

  // ---------------- stage 7: scaled S and V, hue sector ----------------
  pix_t          p7_q;
  fr_t           s7_q, v7_q;
  logic [2:0]    sec7_q;
  logic [HB-1:0] f7_q;

  logic [N+17:0] s_rnd;
  logic [N+16:0] v_rnd;
  logic [HB+2:0] h6x;

  assign s_rnd = (N+18)'(sp6_q) + (N+18)'(hsvab_pkg::GAIN_UNITY >> 1);
  assign v_rnd = (N+17)'(vp6_q) + (N+17)'(hsvab_pkg::GAIN_UNITY >> 1);
  assign h6x   = (HB+3)'(h6_q) * (HB+3)'(6);

  always_ff @(posedge clk_i) begin
    p7_q   <= p6_q;
    s7_q   <= ((s_rnd >> 14) > (N+18)'(FR_ONE)) ? FR_ONE : s_rnd[N+14:14];
    v7_q   <= ((v_rnd >> 14) > (N+17)'(FR_ONE)) ? FR_ONE : v_rnd[N+14:14];
    sec7_q <= h6x[HB+2:HB];
    f7_q   <= h6x[HB-1:0];
  end

  // ---------------- stage 8: saturation times fraction ----------------
  pix_t          p8_q;
  fr_t           s8_q, v8_q;
  logic [2:0]    sec8_q;
  logic [N+16:0] sfp8_q;
  logic [N+17:0] sgp8_q;

  always_ff @(posedge clk_i) begin
    p8_q   <= p7_q;
    s8_q   <= s7_q;
    v8_q   <= v7_q;
    sec8_q <= sec7_q;
    sfp8_q <= (N+17)'(s7_q) * (N+17)'(f7_q);
    sgp8_q <= (N+18)'(s7_q) * (N+18)'(17'h10000 - {1'b0, f7_q});
  end

  // ---------------- stage 9: complements ----------------
  pix_t       p9_q;
  fr_t        v9_q, os9_q, oq9_q, ot9_q;
  logic [2:0] sec9_q;

  logic [N+17:0] sf_rnd;
  logic [N+18:0] sg_rnd;

  assign sf_rnd = (N+18)'(sfp8_q) + (N+18)'(32768);
  assign sg_rnd = (N+19)'(sgp8_q) + (N+19)'(32768);

  always_ff @(posedge clk_i) begin
    p9_q   <= p8_q;
    v9_q   <= v8_q;
    sec9_q <= sec8_q;
    os9_q  <= FR_ONE - s8_q;
    oq9_q  <= FR_ONE - sf_rnd[N+16:16];
    ot9_q  <= FR_ONE - sg_rnd[N+16:16];
  end

  // ---------------- stage 10: value products ----------------
  pix_t          p10_q;
  fr_t           v10_q;
  logic [2:0]    sec10_q;
  logic [2*N+1:0] pp10_q, qp10_q, tp10_q;

  always_ff @(posedge clk_i) begin
    p10_q   <= p9_q;
    v10_q   <= v9_q;
    sec10_q <= sec9_q;
    pp10_q  <= (2*N+2)'(v9_q) * (2*N+2)'(os9_q);
    qp10_q  <= (2*N+2)'(v9_q) * (2*N+2)'(oq9_q);
    tp10_q  <= (2*N+2)'(v9_q) * (2*N+2)'(ot9_q);
  end

  // ---------------- stage 11: sector select ----------------
  pix_t p11_q;
  fr_t  c11_q [3];

  logic [2*N+1:0] half;
  fr_t            pv, qv, tv;
  logic [2*N+1:0] p_rnd, q_rnd, t_rnd;

  assign half  = (2*N+2)'(FR_ONE >> 1);
  assign p_rnd = pp10_q + half;
  assign q_rnd = qp10_q + half;
  assign t_rnd = tp10_q + half;
  assign pv    = p_rnd[2*N:N];
  assign qv    = q_rnd[2*N:N];
  assign tv    = t_rnd[2*N:N];

  always_ff @(posedge clk_i) begin
    p11_q <= p10_q;
    unique case (sec10_q)
      3'd0: begin
        c11_q[0] <= v10_q; c11_q[1] <= tv; c11_q[2] <= pv;
      end
      3'd1: begin
        c11_q[0] <= qv; c11_q[1] <= v10_q; c11_q[2] <= pv;
      end
      3'd2: begin
        c11_q[0] <= pv; c11_q[1] <= v10_q; c11_q[2] <= tv;
      end
      3'd3: begin
        c11_q[0] <= pv; c11_q[1] <= qv; c11_q[2] <= v10_q;
      end
      3'd4: begin
        c11_q[0] <= tv; c11_q[1] <= pv; c11_q[2] <= v10_q;
      end
      default: begin
        c11_q[0] <= v10_q; c11_q[1] <= pv; c11_q[2] <= qv;
      end
    endcase
  end

  // ---------------- stage 12: blend products ----------------
  pix_t          p12_q;
  logic [N+16:0] ba12_q [3];
  logic [N+17:0] bb12_q [3];
  ch_t           orig11 [3];

  assign orig11[0] = p11_q.r;
  assign orig11[1] = p11_q.g;
  assign orig11[2] = p11_q.b;

  always_ff @(posedge clk_i) begin
    p12_q <= p11_q;
    for (int i = 0; i < 3; i++) begin
      ba12_q[i] <= (N+17)'(orig11[i]) * (N+17)'(inv_fac);
      bb12_q[i] <= (N+18)'(c11_q[i]) * (N+18)'(fac);
    end
  end

  // ---------------- stage 13: rounding, clamp, bypass ----------------
  logic [N+18:0] mix [3];
  ch_t           res [3];
  ch_t           orig12 [3];

  assign orig12[0] = p12_q.r;
  assign orig12[1] = p12_q.g;
  assign orig12[2] = p12_q.b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mix[i] = (N+19)'(ba12_q[i]) + (N+19)'(bb12_q[i]) + (N+19)'(32768);
      if (p12_q.byp) begin
        res[i] = orig12[i];
      end else if ((mix[i] >> 16) > (N+19)'(CH_MAX)) begin
        res[i] = CH_MAX;
      end else begin
        res[i] = mix[i][N+15:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    red_out_o   <= res[0];
    green_out_o <= res[1];
    blue_out_o  <= res[2];
    alpha_out_o <= p12_q.a;
  end

  // The last valid bit lines up with the output word register.
  assign done_o = vld_q[NV-1];

endmodule

`default_nettype wire

// ===== rtl/hsvab_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used twice by hsv_adjust_blend_unit.
`default_nettype none

module hsvab_div #(
  parameter int DW = 33,
  parameter int VW = 16,
  parameter int QW = 17
) (
  input  wire logic          clk_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic      [QW-1:0] quotient_o
);

  logic [VW-1:0] rem_in  [QW];
  logic [QW-1:0] low_in  [QW];
  logic [QW-1:0] quo_in  [QW];
  logic [VW-1:0] dvs_in  [QW];
  logic [VW-1:0] rem_q   [QW];
  logic [QW-1:0] low_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [VW-1:0] dvs_q   [QW];

  // The caller guarantees the quotient fits in QW bits, so the upper
  // dividend bits start out below the divisor.
  assign rem_in[0] = VW'(dividend_i >> QW);
  assign low_in[0] = dividend_i[QW-1:0];
  assign quo_in[0] = '0;
  assign dvs_in[0] = divisor_i;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [VW:0] trial;
    logic [VW:0] diff;
    logic        ge;

    if (i > 0) begin : g_link
      assign rem_in[i] = rem_q[i-1];
      assign low_in[i] = low_q[i-1];
      assign quo_in[i] = quo_q[i-1];
      assign dvs_in[i] = dvs_q[i-1];
    end

    assign trial = {rem_in[i], low_in[i][QW-1]};
    assign diff  = trial - {1'b0, dvs_in[i]};
    assign ge    = (trial >= {1'b0, dvs_in[i]});

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? diff[VW-1:0] : trial[VW-1:0];
      low_q[i] <= {low_in[i][QW-2:0], 1'b0};
      quo_q[i] <= {quo_in[i][QW-2:0], ge};
      dvs_q[i] <= dvs_in[i];
    end
  end

  assign quotient_o = quo_q[QW-1];

endmodule

`default_nettype wire
